/* hw/rtl/mmpc_pkg.sv */
// Shared types, constants and helper functions of the meter map position converter.
`timescale 1ns / 1ps
package mmpc_pkg;

	localparam int unsigned TICK_W        = 48;
	localparam int unsigned BAR_W         = 31;
	localparam int unsigned MAX_SIGS      = 16;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned CNT_W         = 5;
	localparam int unsigned BAR_LEN_W     = 20;
	localparam int unsigned BEAT_LEN_W    = 12;
	localparam int unsigned ACC_W         = 53;
	localparam int unsigned IN_DATA_W     = 144;
	localparam int unsigned OUT_DATA_W    = 112;

	// whole-note length in ticks (4 quarters of 960 ticks)
	localparam logic [11:0] WHOLE_TICKS   = 12'd3840;
	localparam logic [7:0]  SIXTEENTH_TICKS = 8'd240;
	localparam logic [7:0]  DEFAULT_SIG   = 8'd4;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic [BAR_W-1:0]  BAR_MAX  = {BAR_W{1'b1}};

	// reciprocal of the sixteenth length, exact for any remainder below a whole note
	localparam logic [12:0] SIX_RECIP       = 13'd4370;
	localparam int unsigned SIX_RECIP_SHIFT = 20;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_T2P    = 2'd2,
		KIND_P2T    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_BAD_SIG = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_NO_RM0  = 3'd3,
		STAT_BAD_POS = 3'd4
	} stat_t;

	typedef enum logic {
		REG_BASE_NUM = 1'b0,
		REG_BASE_DEN = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE        = 4'd0,
		OP_LOAD        = 4'd1,
		OP_ERR         = 4'd2,
		OP_STEP        = 4'd3,
		OP_COMMIT      = 4'd4,
		OP_SEG_INIT    = 4'd5,
		OP_SPAN_START  = 4'd6,
		OP_SPAN_DONE   = 4'd7,
		OP_SINCE_START = 4'd8,
		OP_SINCE_DONE  = 4'd9,
		OP_BEAT_DONE   = 4'd10,
		OP_CALC1       = 4'd12,
		OP_CALC2       = 4'd13,
		OP_CALC3       = 4'd14,
		OP_FIN         = 4'd15
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  err;
		logic  scan_go;
		logic  seg_more;
		logic  span_hit;
		logic  div_busy;
		logic  out_busy;
	} dp_sts_t;

	function automatic logic sig_valid(input logic [7:0] num, input logic [7:0] den);
		return (num != 8'd0) && (den != 8'd0) && (den <= 8'd128) &&
			((den & (den - 8'd1)) == 8'd0);
	endfunction

	function automatic logic [2:0] den_log2(input logic [7:0] den);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (den[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [BAR_LEN_W-1:0] bar_len(input logic [7:0] num,
			input logic [7:0] den);
		logic [BAR_LEN_W-1:0] p;
		p = BAR_LEN_W'(num) * BAR_LEN_W'(WHOLE_TICKS);
		return p >> den_log2(den);
	endfunction

	function automatic logic [BEAT_LEN_W-1:0] beat_len(input logic [7:0] den);
		return WHOLE_TICKS >> den_log2(den);
	endfunction

endpackage

/* hw/rtl/mmpc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mmpc_div
	import mmpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TICK_W-1:0]    dividend,
	input  logic [BAR_LEN_W-1:0] divisor,
	output logic                 busy,
	output logic [TICK_W-1:0]    quot,
	output logic [BAR_LEN_W-1:0] rem
);

	logic [TICK_W-1:0]    quot_q;
	logic [BAR_LEN_W-1:0] rem_q;
	logic [BAR_LEN_W-1:0] dvs_q;
	logic [5:0]           cnt_q;
	logic [BAR_LEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quot_q[TICK_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(TICK_W);
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (cnt_q != 6'd0) begin
			rem_q  <= fits ? BAR_LEN_W'(trial - {1'b0, dvs_q}) : trial[BAR_LEN_W-1:0];
			quot_q <= {quot_q[TICK_W-2:0], fits};
		end
	end

	assign busy = cnt_q != 6'd0;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/mmpc_ctrl.sv */
// Sequencing state machine of the meter map position converter.
`timescale 1ns / 1ps
module mmpc_ctrl
	import mmpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_CHECK  = 11'b000_0000_0010,
		ST_SCAN   = 11'b000_0000_0100,
		ST_SEG    = 11'b000_0000_1000,
		ST_DSPAN  = 11'b000_0001_0000,
		ST_DSINCE = 11'b000_0010_0000,
		ST_DBEAT  = 11'b000_0100_0000,
		ST_CALC1  = 11'b000_1000_0000,
		ST_CALC2  = 11'b001_0000_0000,
		ST_CALC3  = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.err) begin
					cmd.op  = OP_ERR;
					state_d = ST_FIN;
				end else if (sts.kind == KIND_INSERT || sts.kind == KIND_REMOVE) begin
					state_d = ST_SCAN;
				end else begin
					cmd.op  = OP_SEG_INIT;
					state_d = ST_SEG;
				end
			end
			ST_SCAN: begin
				if (sts.scan_go) begin
					cmd.op = OP_STEP;
				end else begin
					cmd.op  = OP_COMMIT;
					state_d = ST_FIN;
				end
			end
			ST_SEG: begin
				if (sts.seg_more) begin
					cmd.op  = OP_SPAN_START;
					state_d = ST_DSPAN;
				end else if (sts.kind == KIND_T2P) begin
					cmd.op  = OP_SINCE_START;
					state_d = ST_DSINCE;
				end else begin
					state_d = ST_CALC1;
				end
			end
			ST_DSPAN: begin
				if (!sts.div_busy) begin
					if (sts.kind == KIND_P2T && sts.span_hit) begin
						state_d = ST_CALC1;
					end else begin
						cmd.op  = OP_SPAN_DONE;
						state_d = ST_SEG;
					end
				end
			end
			ST_DSINCE: begin
				if (!sts.div_busy) begin
					cmd.op  = OP_SINCE_DONE;
					state_d = ST_DBEAT;
				end
			end
			ST_DBEAT: begin
				if (!sts.div_busy) begin
					cmd.op  = OP_BEAT_DONE;
					state_d = ST_FIN;
				end
			end
			ST_CALC1: begin
				cmd.op  = OP_CALC1;
				state_d = ST_CALC2;
			end
			ST_CALC2: begin
				cmd.op  = OP_CALC2;
				state_d = ST_CALC3;
			end
			ST_CALC3: begin
				cmd.op  = OP_CALC3;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/mmpc_datapath.sv */
// Signature table, segment walk registers, arithmetic and output register.
`timescale 1ns / 1ps
module mmpc_datapath
	import mmpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [1:0]            in_kind,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	// captured item
	kind_t              kind_q;
	logic [TICK_W-1:0]  tick_q;
	logic [7:0]         num_q, den_q;
	logic [BAR_W-1:0]   bar_q;
	logic [15:0]        beat_q, six_q, sub_q;

	logic [7:0]         base_num_q, base_den_q;

	logic [TICK_W-1:0]  tab_tick [MAX_SIGS];
	logic [7:0]         tab_num  [MAX_SIGS];
	logic [7:0]         tab_den  [MAX_SIGS];
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   ptr_q;

	// current segment
	logic [TICK_W-1:0]     seg_t0_q;
	logic [BAR_LEN_W-1:0]  seg_tpb_q;
	logic [BEAT_LEN_W-1:0] seg_tpbeat_q;

	logic [TICK_W-1:0]  bars_q;
	logic [BAR_W-1:0]   cur_q;
	logic [ACC_W-1:0]   acc_q;
	logic [7:0]         beat_o_q;
	logic [4:0]         six_o_q;
	logic [11:0]        tis_o_q;
	stat_t              stat_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [TICK_W-1:0]  rd_tick;
	logic [7:0]         rd_num, rd_den;
	logic               in_tab, scan_hit, lead, base_ok;
	logic [7:0]         eff_num, eff_den;
	logic [TICK_W-1:0]  ld_tick;
	logic [7:0]         ld_num, ld_den;
	stat_t              err_code;
	logic               err;
	logic [TICK_W:0]    cur_plus;

	logic               div_start, div_busy;
	logic [TICK_W-1:0]  div_dvd, div_quot;
	logic [BAR_LEN_W-1:0] div_dvs, div_rem;

	logic [24:0]        six_prod;
	logic [4:0]         six_quot;
	logic [11:0]        six_rem;

	logic [BAR_W-1:0]   bar_sat;
	logic [TICK_W-1:0]  tick_sat;

	assign rd_tick = tab_tick[ptr_q[IDX_W-1:0]];
	assign rd_num  = tab_num[ptr_q[IDX_W-1:0]];
	assign rd_den  = tab_den[ptr_q[IDX_W-1:0]];
	assign in_tab  = ptr_q < cnt_q;
	assign scan_hit = in_tab && (rd_tick == tick_q);

	assign lead    = (cnt_q == '0) || (tab_tick[0] != '0);
	assign base_ok = sig_valid(base_num_q, base_den_q);
	assign eff_num = base_ok ? base_num_q : DEFAULT_SIG;
	assign eff_den = base_ok ? base_den_q : DEFAULT_SIG;

	always_comb begin
		if (cmd.op == OP_SEG_INIT && lead) begin
			ld_tick = '0;
			ld_num  = eff_num;
			ld_den  = eff_den;
		end else if (cmd.op == OP_SEG_INIT) begin
			ld_tick = tab_tick[0];
			ld_num  = tab_num[0];
			ld_den  = tab_den[0];
		end else begin
			ld_tick = rd_tick;
			ld_num  = rd_num;
			ld_den  = rd_den;
		end
	end

	always_comb begin
		err_code = STAT_OK;
		unique case (kind_q)
			KIND_INSERT: begin
				if (!sig_valid(num_q, den_q)) begin
					err_code = STAT_BAD_SIG;
				end
			end
			KIND_REMOVE: begin
				if (cnt_q > 5'd1 && tick_q == '0) begin
					err_code = STAT_NO_RM0;
				end
			end
			KIND_T2P: begin
				err_code = STAT_OK;
			end
			KIND_P2T: begin
				if (bar_q == '0 || beat_q == '0 || six_q == '0 || sub_q[15]) begin
					err_code = STAT_BAD_POS;
				end
			end
			default: begin
				err_code = STAT_OK;
			end
		endcase
	end
	assign err = err_code != STAT_OK;

	assign cur_plus = {18'd0, cur_q} + {1'b0, div_quot};

	// split the ticks inside the beat into sixteenths by a reciprocal multiply
	assign six_prod = 25'(div_rem[11:0]) * 25'(SIX_RECIP);
	assign six_quot = six_prod[SIX_RECIP_SHIFT +: 5];
	assign six_rem  = div_rem[11:0] - (12'(six_quot) * 12'(SIXTEENTH_TICKS));

	// divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = seg_tpb_q;
		unique case (cmd.op)
			OP_SPAN_START: begin
				div_start = 1'b1;
				div_dvd   = rd_tick - seg_t0_q;
			end
			OP_SINCE_START: begin
				div_start = 1'b1;
				div_dvd   = tick_q - seg_t0_q;
			end
			OP_SINCE_DONE: begin
				div_start = 1'b1;
				div_dvd   = TICK_W'(div_rem);
				div_dvs   = BAR_LEN_W'(seg_tpbeat_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	mmpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign sts.kind     = kind_q;
	assign sts.err      = err;
	assign sts.scan_go  = in_tab && (rd_tick < tick_q);
	assign sts.seg_more = in_tab && ((kind_q == KIND_P2T) || (rd_tick <= tick_q));
	assign sts.span_hit = {18'd0, bar_q} < cur_plus;
	assign sts.div_busy = div_busy;
	assign sts.out_busy = out_valid_q && !out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_num_q <= DEFAULT_SIG;
			base_den_q <= DEFAULT_SIG;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BASE_NUM: base_num_q <= cfg_data;
				REG_BASE_DEN: base_den_q <= cfg_data;
				default: base_num_q <= base_num_q;
			endcase
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.op == OP_COMMIT) begin
			if (kind_q == KIND_INSERT && !scan_hit && cnt_q != CNT_W'(MAX_SIGS)) begin
				cnt_q <= cnt_q + 5'd1;
			end else if (kind_q == KIND_REMOVE && scan_hit) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// table: replace, shift-insert, shift-remove
	always_ff @(posedge clk) begin
		if (cmd.op == OP_COMMIT) begin
			if (kind_q == KIND_INSERT && scan_hit) begin
				tab_num[ptr_q[IDX_W-1:0]] <= num_q;
				tab_den[ptr_q[IDX_W-1:0]] <= den_q;
			end else if (kind_q == KIND_INSERT && cnt_q != CNT_W'(MAX_SIGS)) begin
				for (int i = 0; i < MAX_SIGS; i++) begin
					if (CNT_W'(i) == ptr_q) begin
						tab_tick[i] <= tick_q;
						tab_num[i]  <= num_q;
						tab_den[i]  <= den_q;
					end else if (i > 0 && CNT_W'(i) > ptr_q) begin
						tab_tick[i] <= tab_tick[i-1];
						tab_num[i]  <= tab_num[i-1];
						tab_den[i]  <= tab_den[i-1];
					end
				end
			end else if (kind_q == KIND_REMOVE && scan_hit) begin
				for (int i = 0; i < MAX_SIGS - 1; i++) begin
					if (CNT_W'(i) >= ptr_q) begin
						tab_tick[i] <= tab_tick[i+1];
						tab_num[i]  <= tab_num[i+1];
						tab_den[i]  <= tab_den[i+1];
					end
				end
			end
		end
	end

	// item, walk and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q   <= kind_t'(in_kind);
				tick_q   <= in_data[47:0];
				num_q    <= in_data[55:48];
				den_q    <= in_data[63:56];
				bar_q    <= in_data[94:64];
				beat_q   <= in_data[110:95];
				six_q    <= in_data[126:111];
				sub_q    <= in_data[142:127];
				ptr_q    <= '0;
				bars_q   <= TICK_W'(1);
				cur_q    <= BAR_W'(1);
				acc_q    <= '0;
				beat_o_q <= '0;
				six_o_q  <= '0;
				tis_o_q  <= '0;
				stat_q   <= STAT_OK;
			end
			OP_ERR: begin
				stat_q <= err_code;
			end
			OP_STEP: begin
				ptr_q <= ptr_q + 5'd1;
			end
			OP_COMMIT: begin
				if (kind_q == KIND_INSERT && !scan_hit && cnt_q == CNT_W'(MAX_SIGS)) begin
					stat_q <= STAT_FULL;
				end
			end
			OP_SEG_INIT: begin
				ptr_q        <= lead ? 5'd0 : 5'd1;
				seg_t0_q     <= ld_tick;
				seg_tpb_q    <= bar_len(ld_num, ld_den);
				seg_tpbeat_q <= beat_len(ld_den);
			end
			OP_SPAN_DONE: begin
				if (kind_q == KIND_T2P) begin
					bars_q <= bars_q + div_quot;
				end else begin
					cur_q <= cur_plus[BAR_W-1:0];
				end
				ptr_q        <= ptr_q + 5'd1;
				seg_t0_q     <= ld_tick;
				seg_tpb_q    <= bar_len(ld_num, ld_den);
				seg_tpbeat_q <= beat_len(ld_den);
			end
			OP_SINCE_DONE: begin
				bars_q <= bars_q + div_quot;
			end
			OP_BEAT_DONE: begin
				beat_o_q <= div_quot[7:0] + 8'd1;
				six_o_q  <= six_quot + 5'd1;
				tis_o_q  <= six_rem;
			end
			OP_CALC1: begin
				acc_q <= ACC_W'(seg_t0_q) + ACC_W'(sub_q[14:0]) +
					ACC_W'((six_q - 16'd1) * 24'(SIXTEENTH_TICKS));
			end
			OP_CALC2: begin
				acc_q <= acc_q + ACC_W'((beat_q - 16'd1) * 28'(seg_tpbeat_q));
			end
			OP_CALC3: begin
				acc_q <= acc_q + ACC_W'((bar_q - cur_q) * 51'(seg_tpb_q));
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign bar_sat  = (bars_q > TICK_W'(BAR_MAX)) ? BAR_MAX : bars_q[BAR_W-1:0];
	assign tick_sat = (acc_q[ACC_W-1:TICK_W] != '0) ? TICK_MAX : acc_q[TICK_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FIN) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIN) begin
			out_data_q <= {
				cnt_q,
				(kind_q == KIND_P2T && stat_q == STAT_OK) ? tick_sat : TICK_W'(0),
				tis_o_q,
				six_o_q,
				beat_o_q,
				(kind_q == KIND_T2P) ? bar_sat : BAR_W'(0),
				stat_q
			};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* hw/rtl/meter_map_position_converter_core.sv */
// Top level of the meter map position converter: controller, datapath, assertions.
`timescale 1ns / 1ps
// Usage:
//   Slave stream (s_*) takes one request word per item; s_tuser carries the kind
//   (insert, remove, tick to position, position to tick). Master stream (m_*) returns
//   exactly one result word per request, in order. cfg_* writes the base signature
//   (index 0 numerator, index 1 denominator); cfg_ready is always high, write only
//   while no request is in flight.
// Sequencing:
//   One request at a time. Insert/remove scan the table, one table entry compared
//   per cycle. Tick to position runs one division per signature segment crossed,
//   then two more; position to tick runs one division per segment examined, then
//   three accumulate steps. Divisions use the bit-serial divider.
// Reset:
//   Clears the entry count, the controller and the output valid; the base
//   signature returns to 4/4. Table contents are not cleared.
// Stall:
//   A finished result is held in the output register until taken; the controller
//   waits in its final state while an earlier word is untaken, and s_tready stays low.
module meter_map_position_converter_core
	import mmpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// tick_in[47:0], sig_numerator[55:48], sig_denominator[63:56], bar_in[94:64],
	// beat_in[110:95], sixteenth_in[126:111], sub_tick_in[142:127], zero pad[143]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[2:0], bar_out[33:3], beat_out[41:34], sixteenth_out[46:42],
	// ticks inside the sixteenth[58:47], tick_out[106:59], entry_count[111:107]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	mmpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mmpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.in_kind   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// one request in flight: after an accept, hold off the next
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("status code out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[111:107] <= 5'd16)
		else $error("entry count above table depth");

endmodule

/* dv/meter_map_position_converter_core_test.sv */
// Self-checking stream testbench for the meter map position converter core.
`timescale 1ns / 1ps
module meter_map_position_converter_core_test;
	import mmpc_pkg::*;

	typedef longint unsigned u64_t;

	// request word, last field in the lowest bits
	typedef struct packed {
		logic              pad;
		logic [15:0]       sub_tick;
		logic [15:0]       sixteenth;
		logic [15:0]       beat;
		logic [BAR_W-1:0]  bar;
		logic [7:0]        den;
		logic [7:0]        num;
		logic [TICK_W-1:0] tick;
	} meter_req_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic [4:0]        entry_count;
		logic [TICK_W-1:0] tick_out;
		logic [11:0]       tick_in_six;
		logic [4:0]        six_out;
		logic [7:0]        beat_out;
		logic [BAR_W-1:0]  bar_out;
		stat_t             status;
	} meter_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [7:0]            cfg_data;

	meter_map_position_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the signature table and base registers
	u64_t       sig_ticks [MAX_SIGS];
	logic [7:0] sig_nums  [MAX_SIGS];
	logic [7:0] sig_dens  [MAX_SIGS];
	int         sig_total;
	logic [7:0] base_num;
	logic [7:0] base_den;

	meter_res_t pending_results[$];
	int         mismatch_count;
	int         burst_left;
	int         ready_mode;   // 0 always ready, 1 random stalls, 2 mostly alternating random stalls
	int         hold_cycles;  // long receiver hold-off, counted down by the receiver

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic sig_ok(logic [7:0] num, logic [7:0] den);
		return num != 0 && den != 0 && den <= 128 && (den & (den - 8'd1)) == 0;
	endfunction

	function automatic u64_t whole_bar(logic [7:0] num, logic [7:0] den);
		return (u64_t'(num) * 64'd3840) / u64_t'(den);
	endfunction

	// Compute the result word for one request and update the shadow table.
	function automatic meter_res_t predict_meter_result(kind_t kind, meter_req_t rq);
		meter_res_t r;
		u64_t       et [MAX_SIGS + 1];
		logic [7:0] en [MAX_SIGS + 1];
		logic [7:0] ed [MAX_SIGS + 1];
		int         n, k, p, idx;
		logic       lead, found;
		u64_t       bars, tpb, tpbeat, since, in_bar, in_beat, cur, span, sum;
		u64_t       tick;
		r = '0;
		tick = u64_t'(rq.tick);
		case (kind)
			KIND_INSERT: begin
				found = 1'b0;
				if (!sig_ok(rq.num, rq.den)) begin
					r.status = STAT_BAD_SIG;
				end else begin
					for (int i = 0; i < sig_total; i++) begin
						if (!found && sig_ticks[i] == tick) begin
							sig_nums[i] = rq.num;
							sig_dens[i] = rq.den;
							found = 1'b1;
						end
					end
					if (!found && sig_total >= MAX_SIGS) begin
						r.status = STAT_FULL;
					end else if (!found) begin
						p = 0;
						while (p < sig_total && sig_ticks[p] < tick)
							p++;
						for (int i = sig_total; i > p; i--) begin
							sig_ticks[i] = sig_ticks[i-1];
							sig_nums[i]  = sig_nums[i-1];
							sig_dens[i]  = sig_dens[i-1];
						end
						sig_ticks[p] = tick;
						sig_nums[p]  = rq.num;
						sig_dens[p]  = rq.den;
						sig_total++;
					end
				end
			end
			KIND_REMOVE: begin
				if (sig_total > 1 && tick == 0) begin
					r.status = STAT_NO_RM0;
				end else begin
					idx = -1;
					for (int i = 0; i < sig_total; i++)
						if (idx < 0 && sig_ticks[i] == tick)
							idx = i;
					if (idx >= 0) begin
						for (int i = idx; i + 1 < sig_total; i++) begin
							sig_ticks[i] = sig_ticks[i+1];
							sig_nums[i]  = sig_nums[i+1];
							sig_dens[i]  = sig_dens[i+1];
						end
						sig_total--;
					end
				end
			end
			default: begin
				// effective segment list: base signature at tick 0 unless the table has one
				lead = sig_total == 0 || sig_ticks[0] > 0;
				n = 0;
				if (lead) begin
					et[0] = 0;
					en[0] = sig_ok(base_num, base_den) ? base_num : 8'd4;
					ed[0] = sig_ok(base_num, base_den) ? base_den : 8'd4;
					n = 1;
				end
				for (int i = 0; i < sig_total; i++) begin
					et[n] = sig_ticks[i];
					en[n] = sig_nums[i];
					ed[n] = sig_dens[i];
					n++;
				end
				if (kind == KIND_T2P) begin
					k = 0;
					for (int i = 0; i < n; i++)
						if (et[i] <= tick)
							k = i;
					bars = 1;
					for (int i = 0; i < k; i++)
						bars += (et[i+1] - et[i]) / whole_bar(en[i], ed[i]);
					tpb = whole_bar(en[k], ed[k]);
					tpbeat = 64'd3840 / u64_t'(ed[k]);
					since = tick - et[k];
					bars += since / tpb;
					r.bar_out = bars > 64'h7FFF_FFFF ? BAR_MAX : BAR_W'(bars);
					in_bar = since % tpb;
					r.beat_out = 8'(1 + in_bar / tpbeat);
					in_beat = in_bar % tpbeat;
					r.six_out = 5'(1 + in_beat / 240);
					r.tick_in_six = 12'(in_beat % 240);
				end else if (rq.bar == 0 || rq.beat == 0 || rq.sixteenth == 0 ||
						rq.sub_tick[15]) begin
					r.status = STAT_BAD_POS;
				end else begin
					cur = 1;
					found = 1'b0;
					for (int i = 0; i < n; i++) begin
						if (!found) begin
							tpb = whole_bar(en[i], ed[i]);
							span = (i + 1 < n) ? (et[i+1] - et[i]) / tpb
								: u64_t'(rq.bar) - cur + 1;
							if (u64_t'(rq.bar) < cur + span) begin
								sum = et[i] + (u64_t'(rq.bar) - cur) * tpb +
									(u64_t'(rq.beat) - 1) * (64'd3840 / u64_t'(ed[i])) +
									(u64_t'(rq.sixteenth) - 1) * 240 + u64_t'(rq.sub_tick);
								r.tick_out = sum > 64'hFFFF_FFFF_FFFF ? TICK_MAX
									: TICK_W'(sum);
								found = 1'b1;
							end
							cur += span;
						end
					end
				end
			end
		endcase
		r.entry_count = 5'(sig_total);
		return r;
	endfunction

	task automatic report_mismatch(string what, u64_t got, u64_t want);
		$display("mismatch %0s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		meter_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = meter_res_t'(m_tdata);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
				if (got.bar_out != want.bar_out)
					report_mismatch("bar_out", got.bar_out, want.bar_out);
				if (got.beat_out != want.beat_out)
					report_mismatch("beat_out", got.beat_out, want.beat_out);
				if (got.six_out != want.six_out)
					report_mismatch("sixteenth_out", got.six_out, want.six_out);
				if (got.tick_in_six != want.tick_in_six)
					report_mismatch("tick_in_six", got.tick_in_six, want.tick_in_six);
				if (got.tick_out != want.tick_out)
					report_mismatch("tick_out", got.tick_out, want.tick_out);
				if (got.entry_count != want.entry_count)
					report_mismatch("entry_count", got.entry_count, want.entry_count);
			end
		end
	end

	// Receiver: drive m_tready on the falling edge, honoring long hold-offs first
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready = 1'b0;
			hold_cycles--;
		end else begin
			case (ready_mode)
				1:       m_tready = $urandom_range(0, 99) >= 35;
				2:       m_tready = ($urandom_range(0, 7) != 0) ^ m_tready;
				default: m_tready = 1'b1;
			endcase
		end
	end

	// Offer one word; after it is accepted, return on the next falling edge or after a random gap.
	task automatic send_word(kind_t kind, meter_req_t rq);
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = rq;
		do @(posedge clk); while (!s_tready);
		pending_results = {pending_results, predict_meter_result(kind, rq)};
		@(negedge clk);
		// bursts of random length with random gaps
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40)
				: $urandom_range(0, 5);
		end
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_BASE_NUM)
			base_num = value;
		else
			base_den = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_base(logic [7:0] num, logic [7:0] den);
		wait_idle();
		write_reg(REG_BASE_NUM, num);
		write_reg(REG_BASE_DEN, den);
	endtask

	function automatic meter_req_t noise_req();
		meter_req_t rq;
		rq.tick      = {16'($urandom), 32'($urandom)};
		rq.num       = 8'($urandom);
		rq.den       = 8'($urandom);
		rq.bar       = BAR_W'($urandom);
		rq.beat      = 16'($urandom);
		rq.sixteenth = 16'($urandom);
		rq.sub_tick  = 16'($urandom);
		rq.pad       = 1'b0;
		return rq;
	endfunction

	task automatic send_t2p(u64_t tick);
		meter_req_t rq;
		rq = noise_req();
		rq.tick = TICK_W'(tick);
		send_word(KIND_T2P, rq);
	endtask

	task automatic send_p2t(u64_t bar, int beat, int six, int sub);
		meter_req_t rq;
		rq = noise_req();
		rq.bar = BAR_W'(bar);
		rq.beat = 16'(beat);
		rq.sixteenth = 16'(six);
		rq.sub_tick = 16'(sub);
		send_word(KIND_P2T, rq);
	endtask

	task automatic send_edit(kind_t kind, u64_t tick, int num, int den);
		meter_req_t rq;
		rq = noise_req();
		rq.tick = TICK_W'(tick);
		rq.num = 8'(num);
		rq.den = 8'(den);
		send_word(kind, rq);
	endtask

	// Conversions (first run on an empty table): extremes and every bad position field
	task automatic test_empty_table();
		send_t2p(0);
		send_t2p(64'hFFFF_FFFF_FFFF);
		send_p2t(1, 1, 1, 0);
		send_p2t(64'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
		send_p2t(0, 1, 1, 0);
		send_p2t(1, 0, 1, 0);
		send_p2t(1, 1, 0, 0);
		send_p2t(1, 1, 1, -1);
	endtask

	// Bad signatures, fill to full, replace while full, protected tick-0 removal
	task automatic test_table_edits();
		send_edit(KIND_INSERT, 100, 0, 4);
		send_edit(KIND_INSERT, 100, 3, 0);
		send_edit(KIND_INSERT, 100, 3, 3);
		send_edit(KIND_INSERT, 100, 255, 255);
		send_edit(KIND_INSERT, 64'hFFFF_FFFF_FFFF, 255, 128);
		for (int i = 0; i < MAX_SIGS - 1; i++)
			send_edit(KIND_INSERT, u64_t'(i) * 7000, $urandom_range(1, 12),
				1 << $urandom_range(0, 7));
		send_edit(KIND_INSERT, 12345, 3, 4);
		send_edit(KIND_INSERT, 7000, 1, 1);
		send_edit(KIND_REMOVE, 0, 0, 0);
		send_edit(KIND_REMOVE, 99, 0, 0);
		send_t2p(50000);
		send_p2t(40, 2, 3, 17);
		send_edit(KIND_REMOVE, 64'hFFFF_FFFF_FFFF, 0, 0);
	endtask

	// Random mix biased toward well-formed edits near the populated ticks
	task automatic test_random_mix(int count);
		meter_req_t rq;
		kind_t      kind;
		int         sel;
		for (int n = 0; n < count; n++) begin
			rq = noise_req();
			sel = $urandom_range(0, 99);
			kind = sel < 25 ? KIND_INSERT : sel < 40 ? KIND_REMOVE
				: sel < 70 ? KIND_T2P : KIND_P2T;
			sel = $urandom_range(0, 99);
			if (sel < 55)
				rq.tick = TICK_W'($urandom_range(0, 400000));
			else if (sel < 75 && sig_total > 0)
				rq.tick = TICK_W'(sig_ticks[$urandom_range(0, sig_total - 1)]);
			else if (sel < 85)
				rq.tick = '0;
			if ($urandom_range(0, 9) != 0) begin
				rq.num = $urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(1, 13));
				rq.den = 8'd1 << $urandom_range(0, 7);
			end
			sel = $urandom_range(0, 99);
			if (sel < 75)
				rq.bar = BAR_W'($urandom_range(1, 80));
			else if (sel < 80)
				rq.bar = '0;
			if ($urandom_range(0, 9) != 0) begin
				rq.beat = 16'($urandom_range(1, 16));
				rq.sixteenth = 16'($urandom_range(1, 20));
				rq.sub_tick = 16'($urandom_range(0, 500));
			end
			send_word(kind, rq);
		end
	endtask

	// Hold the receiver off so results back up and the input stalls
	task automatic test_backpressure();
		wait_idle();
		hold_cycles = 4000;
		test_random_mix(30);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_INSERT;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_NUM;
		cfg_data = '0;
		sig_total = 0;
		base_num = 8'd4;
		base_den = 8'd4;
		mismatch_count = 0;
		burst_left = 0;
		ready_mode = 0;
		hold_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		ready_mode = 1;
		test_table_edits();
		test_random_mix(250);
		set_base(8'd1, 8'd1);
		ready_mode = 2;
		test_random_mix(250);
		set_base(8'd255, 8'd128);
		test_empty_table();
		test_random_mix(250);
		set_base(8'd0, 8'd3);
		ready_mode = 0;
		test_random_mix(250);
		test_backpressure();
		set_base(8'd7, 8'd8);
		ready_mode = 1;
		test_random_mix(350);

		// drain: wait for all results, then let the block settle
		wait_idle();
		repeat (200) @(negedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Run limit well beyond the slowest legal run
	initial begin
		#100ms;
		$display("FAILURE");
		$finish;
	end

endmodule
